@@ hdl/wve_pkg.sv @@
// Package for the wavetable voice: opcodes, envelope stages, controller states,
// controller/datapath command structs, fixed-point constants and the pitch and onset ROMs.
// No dependencies.
`timescale 1ns / 1ps

package wve_pkg;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_NOTE_ON     = 2'd1,
        OP_NOTE_OFF    = 2'd2,
        OP_TABLE_WRITE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STG_ON      = 3'd0,
        STG_ATTACK  = 3'd1,
        STG_DECAY   = 3'd2,
        STG_SUSTAIN = 3'd3,
        STG_RELEASE = 3'd4,
        STG_OFF     = 3'd5
    } t_stage;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVENT,
        S_ADVANCE,
        S_WRAP,
        S_ENVELOPE,
        S_READ,
        S_MULTIPLY,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic apply_event;
        logic advance;
        logic wrap;
        logic envelope;
        logic read;
        logic multiply;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic playing;
    } t_ctrl_status;

    localparam int STEP_W  = 25;
    localparam int LEVEL_W = 24;
    localparam int K_W     = 17;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 24'd65536;
    localparam logic [LEVEL_W-1:0] OFF_LEVEL   = 24'd655;
    localparam logic [6:0]         VEL_RESET   = 7'd1;
    localparam logic [6:0]         NOTE_RESET  = 7'd69;

    // Q16 envelope multipliers: 1.075, 0.995 and 0.7.
    localparam logic [K_W-1:0] K_ATTACK  = 17'd70451;
    localparam logic [K_W-1:0] K_DECAY   = 17'd65208;
    localparam logic [K_W-1:0] K_RELEASE = 17'd45875;

    // Stage thresholds per unit of velocity; decay and release compare 10 times the level.
    localparam logic [23:0] ATTACK_LIM  = 24'd98304;
    localparam logic [27:0] DECAY_LIM   = 28'd589824;
    localparam logic [27:0] RELEASE_LIM = 28'd65536;

    typedef logic [STEP_W-1:0]  t_step_rom  [128];
    typedef logic [LEVEL_W-1:0] t_level_rom [128];

    localparam longint unsigned SEMITONE_Q30 [12] = '{
        64'd1073741824, 64'd1137589835, 64'd1205234447, 64'd1276901417,
        64'd1352829926, 64'd1433273380, 64'd1518500250, 64'd1608794974,
        64'd1704458901, 64'd1805811301, 64'd1913190429, 64'd2026954652
    };

    // Step for each note: 2^((note-21)/12) in Q16, rounded half up.
    function automatic t_step_rom build_pitch_rom();
        t_step_rom        rom;
        int               d;
        int               sh;
        longint unsigned  v;
        for (int n = 0; n < 128; n++) begin
            d  = n + 3;
            sh = 16 - d / 12;
            v  = SEMITONE_Q30[d % 12];
            v  = (v + (64'd1 << (sh - 1))) >> sh;
            rom[n] = v[STEP_W-1:0];
        end
        return rom;
    endfunction

    // Note-on level: round(velocity * 0.8) in Q16.
    function automatic t_level_rom build_onset_rom();
        t_level_rom rom;
        longint     v;
        for (int n = 0; n < 128; n++) begin
            v = (longint'(n) * 64'd524288 + 64'd5) / 10;
            rom[n] = v[LEVEL_W-1:0];
        end
        return rom;
    endfunction

    localparam t_step_rom  PITCH_ROM = build_pitch_rom();
    localparam t_level_rom ONSET_ROM = build_onset_rom();

endpackage

@@ hdl/wve_if.sv @@
// Handshake channels of the wavetable voice: event requests in, result requests out.
// Depends on nothing; payload fields follow the voice's item formats.
`timescale 1ns / 1ps

interface wve_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [6:0]         note_number;
    logic [6:0]         velocity;
    logic [10:0]        table_address;
    logic signed [15:0] table_word;

    modport source (output valid, output op, output note_number, output velocity,
                    output table_address, output table_word, input ready);
    modport sink   (input valid, input op, input note_number, input velocity,
                    input table_address, input table_word, output ready);
endinterface

interface wve_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] sample_out;
    logic               voice_active;
    logic [6:0]         current_note;
    logic [2:0]         envelope_stage;

    modport source (output valid, output sample_out, output voice_active,
                    output current_note, output envelope_stage, input ready);
    modport sink   (input valid, input sample_out, input voice_active,
                    input current_note, input envelope_stage, output ready);
endinterface

@@ hdl/wve_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wve_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1600
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/wve_ctrl.sv @@
// Controller of the wavetable voice: sequences each request through the datapath
// and owns both handshakes. Depends on wve_pkg.
`timescale 1ns / 1ps

module wve_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_in_op,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  wve_pkg::t_ctrl_status i_status,
    output wve_pkg::t_ctrl_cmd   o_cmd
);

    wve_pkg::t_state r_state;
    wve_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            wve_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_op != wve_pkg::OP_TICK) begin
                        n_state = wve_pkg::S_EVENT;
                    end else if (i_status.playing) begin
                        n_state = wve_pkg::S_ADVANCE;
                    end else begin
                        // A silent voice holds its phase and answers at once.
                        n_state = wve_pkg::S_EMIT;
                    end
                end
            end
            wve_pkg::S_EVENT:    n_state = wve_pkg::S_EMIT;
            wve_pkg::S_ADVANCE:  n_state = wve_pkg::S_WRAP;
            wve_pkg::S_WRAP:     n_state = wve_pkg::S_ENVELOPE;
            wve_pkg::S_ENVELOPE: n_state = wve_pkg::S_READ;
            wve_pkg::S_READ:     n_state = wve_pkg::S_MULTIPLY;
            wve_pkg::S_MULTIPLY: n_state = wve_pkg::S_EMIT;
            wve_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_state = wve_pkg::S_IDLE;
                end
            end
            default:             n_state = wve_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.capture     = (r_state == wve_pkg::S_IDLE) && i_in_valid;
        o_cmd.apply_event = (r_state == wve_pkg::S_EVENT);
        o_cmd.advance     = (r_state == wve_pkg::S_ADVANCE);
        o_cmd.wrap        = (r_state == wve_pkg::S_WRAP);
        o_cmd.envelope    = (r_state == wve_pkg::S_ENVELOPE);
        o_cmd.read        = (r_state == wve_pkg::S_READ);
        o_cmd.multiply    = (r_state == wve_pkg::S_MULTIPLY);
        o_cmd.emit        = (r_state == wve_pkg::S_EMIT) && w_out_free;
        o_in_ready        = (r_state == wve_pkg::S_IDLE);
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wve_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hdl/wve_datapath.sv @@
// Datapath of the wavetable voice: phase accumulator, envelope, wavetable RAM,
// sample multiplier and result register. Depends on wve_pkg and wve_ram.
`timescale 1ns / 1ps

module wve_datapath #(
    parameter int TABLE_LENGTH = 1600
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wve_pkg::t_ctrl_cmd    i_cmd,
    output wve_pkg::t_ctrl_status o_status,
    input  logic [1:0]            i_op,
    input  logic [6:0]            i_note_number,
    input  logic [6:0]            i_velocity,
    input  logic [10:0]           i_table_address,
    input  logic signed [15:0]    i_table_word,
    output logic signed [23:0]    o_sample_out,
    output logic                  o_voice_active,
    output logic [6:0]            o_current_note,
    output logic [2:0]            o_envelope_stage
);

    localparam int ADDR_W = $clog2(TABLE_LENGTH);
    // Room for a phase just below the limit plus the largest step.
    localparam int PH_W   = (((ADDR_W + 16) > wve_pkg::STEP_W) ?
                             (ADDR_W + 16) : wve_pkg::STEP_W) + 1;
    localparam logic [PH_W-1:0] PHASE_LIMIT = PH_W'(TABLE_LENGTH) << 16;

    // Captured request fields.
    wve_pkg::t_op       r_op;
    logic [6:0]         r_note_in;
    logic [6:0]         r_vel_in;
    logic [10:0]        r_addr_in;
    logic signed [15:0] r_word_in;

    // Voice state.
    logic [PH_W-1:0]              r_phase;
    logic [PH_W-1:0]              n_phase;
    logic [wve_pkg::STEP_W-1:0]   r_step;
    logic [wve_pkg::STEP_W-1:0]   n_step;
    logic [wve_pkg::LEVEL_W-1:0]  r_level;
    logic [wve_pkg::LEVEL_W-1:0]  n_level;
    logic [6:0]                   r_velocity;
    logic [6:0]                   n_velocity;
    logic [6:0]                   r_note;
    logic [6:0]                   n_note;
    wve_pkg::t_stage              r_stage;
    wve_pkg::t_stage              n_stage;
    logic                         r_playing;
    logic                         n_playing;
    logic                         r_wrapped;
    logic                         r_tick_sample;
    logic signed [40:0]           r_prod;

    // Result register.
    logic signed [23:0] r_sample_out;
    logic               r_voice_active;
    logic [6:0]         r_current_note;
    logic [2:0]         r_envelope_stage;

    logic [PH_W-1:0]              w_phase_sum;
    logic [PH_W:0]                w_phase_diff;
    logic                         w_phase_over;
    logic [wve_pkg::LEVEL_W-1:0]  w_scale_base;
    logic [wve_pkg::K_W-1:0]      w_scale_k;
    logic [40:0]                  w_scale_prod;
    logic [40:0]                  w_scale_round;
    logic [wve_pkg::LEVEL_W-1:0]  w_scaled;
    logic [23:0]                  w_attack_lim;
    logic [27:0]                  w_level_x10;
    logic [27:0]                  w_decay_lim;
    logic [27:0]                  w_release_lim;
    logic                         w_ram_we;
    logic [ADDR_W-1:0]            w_ram_waddr;
    logic [ADDR_W-1:0]            w_ram_raddr;
    logic [15:0]                  w_ram_rdata;
    logic signed [40:0]           w_round;
    logic signed [24:0]           w_q;
    logic signed [23:0]           w_sat;

    // Phase: add, then up to two reductions by the table length.
    assign w_phase_sum  = r_phase + PH_W'(r_step);
    assign w_phase_diff = {1'b0, r_phase} - {1'b0, PHASE_LIMIT};
    assign w_phase_over = !w_phase_diff[PH_W];

    always_comb begin
        n_phase = r_phase;
        if (i_cmd.advance) begin
            n_phase = w_phase_sum;
        end else if ((i_cmd.wrap || i_cmd.envelope) && w_phase_over) begin
            n_phase = w_phase_diff[PH_W-1:0];
        end
    end

    // Envelope scaling: level times a Q16 factor, rounded half up, clamped to 24 bits.
    assign w_scale_base  = (r_stage == wve_pkg::STG_ON) ?
                           wve_pkg::ONSET_ROM[r_velocity] : r_level;

    always_comb begin
        case (r_stage)
            wve_pkg::STG_DECAY:   w_scale_k = wve_pkg::K_DECAY;
            wve_pkg::STG_RELEASE: w_scale_k = wve_pkg::K_RELEASE;
            default:              w_scale_k = wve_pkg::K_ATTACK;
        endcase
    end

    assign w_scale_prod  = 41'(w_scale_base) * 41'(w_scale_k);
    assign w_scale_round = w_scale_prod + 41'd32768;
    assign w_scaled      = w_scale_round[40] ? {wve_pkg::LEVEL_W{1'b1}} :
                           (w_scale_round[40:16] > 25'h0FFFFFF) ?
                           {wve_pkg::LEVEL_W{1'b1}} : w_scale_round[39:16];

    assign w_attack_lim  = 24'(r_velocity) * wve_pkg::ATTACK_LIM;
    assign w_level_x10   = 28'(r_level) * 28'd10;
    assign w_decay_lim   = 28'(r_velocity) * wve_pkg::DECAY_LIM;
    assign w_release_lim = 28'(r_velocity) * wve_pkg::RELEASE_LIM;

    always_comb begin
        n_step     = r_step;
        n_level    = r_level;
        n_velocity = r_velocity;
        n_note     = r_note;
        n_stage    = r_stage;
        n_playing  = r_playing;
        if (i_cmd.apply_event) begin
            case (r_op)
                wve_pkg::OP_NOTE_ON: begin
                    n_playing  = 1'b1;
                    n_stage    = wve_pkg::STG_ON;
                    n_velocity = r_vel_in;
                    n_note     = r_note_in;
                    n_step     = wve_pkg::PITCH_ROM[r_note_in];
                end
                wve_pkg::OP_NOTE_OFF: begin
                    n_stage = wve_pkg::STG_RELEASE;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.envelope && r_wrapped) begin
            case (r_stage)
                wve_pkg::STG_ON: begin
                    // The onset level never exceeds the attack threshold, so attack scales it.
                    n_playing = 1'b1;
                    n_stage   = wve_pkg::STG_ATTACK;
                    n_level   = w_scaled;
                end
                wve_pkg::STG_ATTACK: begin
                    if (r_level > w_attack_lim) begin
                        n_stage = wve_pkg::STG_DECAY;
                    end else begin
                        n_level = w_scaled;
                    end
                end
                wve_pkg::STG_DECAY: begin
                    if (w_level_x10 < w_decay_lim) begin
                        n_stage = wve_pkg::STG_SUSTAIN;
                    end else begin
                        n_level = w_scaled;
                    end
                end
                wve_pkg::STG_RELEASE: begin
                    if (w_level_x10 < w_release_lim) begin
                        n_stage = wve_pkg::STG_OFF;
                    end else begin
                        n_level = w_scaled;
                    end
                end
                wve_pkg::STG_OFF: begin
                    n_level   = wve_pkg::OFF_LEVEL;
                    n_playing = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_step     <= '0;
            r_level    <= wve_pkg::LEVEL_RESET;
            r_velocity <= wve_pkg::VEL_RESET;
            r_note     <= wve_pkg::NOTE_RESET;
            r_stage    <= wve_pkg::STG_ATTACK;
            r_playing  <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_step     <= n_step;
            r_level    <= n_level;
            r_velocity <= n_velocity;
            r_note     <= n_note;
            r_stage    <= n_stage;
            r_playing  <= n_playing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op          <= wve_pkg::t_op'(i_op);
            r_note_in     <= i_note_number;
            r_vel_in      <= i_velocity;
            r_addr_in     <= i_table_address;
            r_word_in     <= i_table_word;
            r_tick_sample <= 1'b0;
        end else if (i_cmd.multiply) begin
            r_tick_sample <= 1'b1;
        end
        if (i_cmd.wrap) begin
            r_wrapped <= w_phase_over;
        end
        if (i_cmd.multiply) begin
            r_prod <= $signed(w_ram_rdata) * $signed({1'b0, r_level});
        end
    end

    // Wavetable; writes beyond the table length are dropped.
    assign w_ram_we    = i_cmd.apply_event && (r_op == wve_pkg::OP_TABLE_WRITE) &&
                         ({21'd0, r_addr_in} < 32'(TABLE_LENGTH));
    assign w_ram_waddr = ADDR_W'(r_addr_in);
    assign w_ram_raddr = r_phase[ADDR_W+15:16];

    wve_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_LENGTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (r_word_in),
        .i_re    (i_cmd.read),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Round half up, then saturate to Q8.15.
    assign w_round = r_prod + 41'sd32768;
    assign w_q     = w_round[40:16];
    assign w_sat   = (w_q[24] != w_q[23]) ? (w_q[24] ? 24'sh800000 : 24'sh7FFFFF) :
                     w_q[23:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_sample_out     <= r_tick_sample ? w_sat : 24'sd0;
            r_voice_active   <= r_playing;
            r_current_note   <= r_note;
            r_envelope_stage <= r_stage;
        end
    end

    assign o_status.playing = r_playing;
    assign o_sample_out     = r_sample_out;
    assign o_voice_active   = r_voice_active;
    assign o_current_note   = r_current_note;
    assign o_envelope_stage = r_envelope_stage;

endmodule

@@ hdl/wavetable_voice_envelope_core.sv @@
// Tick on a playing voice: the one controller walks phase add, wrap, envelope step, table
// RAM read and sample multiply before the result is registered. Note events and table
// writes take one event step, and a tick on a silent voice goes straight to the result.
// The next request is taken only after the result is registered, which waits on a stalled output.
// Reset (synchronous, active low) restores the voice state; the wavetable is not cleared.
`timescale 1ns / 1ps

module wavetable_voice_envelope_core #(
    parameter int TABLE_LENGTH = 1600
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wve_in_if.sink    i_event,
    wve_out_if.source o_result
);

    wve_pkg::t_ctrl_cmd    w_cmd;
    wve_pkg::t_ctrl_status w_status;
    logic                  w_in_ready;
    logic                  w_out_valid;

    wve_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_event.valid),
        .i_in_op     (i_event.op),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_result.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    wve_datapath #(
        .TABLE_LENGTH (TABLE_LENGTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_op             (i_event.op),
        .i_note_number    (i_event.note_number),
        .i_velocity       (i_event.velocity),
        .i_table_address  (i_event.table_address),
        .i_table_word     (i_event.table_word),
        .o_sample_out     (o_result.sample_out),
        .o_voice_active   (o_result.voice_active),
        .o_current_note   (o_result.current_note),
        .o_envelope_stage (o_result.envelope_stage)
    );

    assign i_event.ready  = w_in_ready;
    assign o_result.valid = w_out_valid;

endmodule

@@ hdl/wve_checker.sv @@
// Port-level checks on the wavetable voice, bound to the top level.
// Depends on wve_pkg and wavetable_voice_envelope_core.
`timescale 1ns / 1ps

module wve_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [23:0] i_sample_out,
    input logic        i_voice_active,
    input logic [2:0]  i_envelope_stage
);

    // Reset empties the result register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // One request at a time: a taken request closes the input until it is finished.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a request was taken");

    // A silent voice only sounds on the tick that stopped it, which leaves the stage off.
    a_silent_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_voice_active && (i_sample_out != 24'd0)) |->
        (i_envelope_stage == wve_pkg::STG_OFF))
        else $error("nonzero sample from a silent voice outside the off stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_sample_out)))
        else $error("stalled result changed");

endmodule

bind wavetable_voice_envelope_core wve_checker u_wve_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_event.valid),
    .i_in_ready       (i_event.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_sample_out     (o_result.sample_out),
    .i_voice_active   (o_result.voice_active),
    .i_envelope_stage (o_result.envelope_stage)
);

@@ verif/wavetable_voice_envelope_core_test.sv @@
// Self-checking test of the wavetable voice: directed event table, wavetable load, then
// random note sequences, scored against an in-bench voice predictor or typed results.
// Depends on wve_pkg (opcodes, stages) and the wve_in_if / wve_out_if channels.
`timescale 1ns / 1ps

module wavetable_voice_envelope_core_test;

    localparam int TABLE_LEN      = 1600;
    localparam int RANDOM_ITEMS   = 650;
    localparam int TAIL_CYCLES    = 16;
    // Longest quiet stretch is a drawn request gap, a tick on a playing voice and a drawn
    // result stall; the limit leaves a wide margin over that.
    localparam int WATCHDOG_LIMIT = 400;

    localparam logic [31:0] PHASE_LIMIT = 32'(TABLE_LEN) << 16;
    localparam longint unsigned RATIO_Q30 [12] = '{
        64'd1073741824, 64'd1137589835, 64'd1205234447, 64'd1276901417,
        64'd1352829926, 64'd1433273380, 64'd1518500250, 64'd1608794974,
        64'd1704458901, 64'd1805811301, 64'd1913190429, 64'd2026954652
    };
    localparam longint unsigned ATTACK_GAIN   = 64'd70451;
    localparam longint unsigned DECAY_GAIN    = 64'd65208;
    localparam longint unsigned RELEASE_GAIN  = 64'd45875;
    localparam longint unsigned ATTACK_PEAK   = 64'd98304;
    localparam longint unsigned DECAY_FLOOR   = 64'd589824;
    localparam longint unsigned RELEASE_FLOOR = 64'd65536;
    localparam logic [23:0]     SILENT_LEVEL  = 24'd655;

    typedef struct packed {
        wve_pkg::t_op       op;
        logic [6:0]         note;
        logic [6:0]         vel;
        logic [10:0]        addr;
        logic signed [15:0] word;
    } voice_req_t;

    typedef struct packed {
        logic signed [23:0] sample;
        logic               active;
        logic [6:0]         note;
        logic [2:0]         stage;
    } voice_res_t;

    typedef struct {
        bit         load_table;
        voice_req_t req;
        bit         typed;
        voice_res_t res;
    } directed_row_t;

    logic clk;
    logic rst_n;

    wve_in_if  ev_if ();
    wve_out_if res_if ();

    wavetable_voice_envelope_core #(
        .TABLE_LENGTH(TABLE_LEN)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_event (ev_if),
        .o_result(res_if)
    );

    // Predicted voice state, starting from the reset values.
    logic [31:0]        phase_acc = '0;
    logic [24:0]        phase_inc = '0;
    logic [23:0]        level_q   = 24'd65536;
    logic [6:0]         vel_q     = 7'd1;
    logic [6:0]         note_q    = 7'd69;
    wve_pkg::t_stage    stage_q   = wve_pkg::STG_ATTACK;
    bit                 playing_q = 1'b0;
    logic signed [15:0] wave_mem [TABLE_LEN];

    voice_res_t    pending_voice_results [$];
    directed_row_t directed_rows [$];
    int            mismatch_count = 0;
    int            results_seen   = 0;
    int            sent_count     = 0;
    bit            no_idle        = 1'b0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [24:0] note_pitch_step(logic [6:0] n);
        int unsigned     d;
        int unsigned     sh;
        longint unsigned r;
        d  = n + 3;
        sh = 16 - d / 12;
        r  = RATIO_Q30[d % 12];
        r  = (r + (64'd1 << (sh - 1))) >> sh;
        return r[24:0];
    endfunction

    function automatic logic [23:0] scale_level(logic [23:0] e, longint unsigned k);
        longint unsigned p;
        p = (64'(e) * k + 64'd32768) >> 16;
        return (p > 64'hFF_FFFF) ? 24'hFF_FFFF : p[23:0];
    endfunction

    // One envelope move, taken on each phase wrap. The onset stage falls
    // straight into the first attack evaluation.
    function automatic void advance_envelope();
        longint unsigned e;
        longint unsigned v;
        v = 64'(vel_q);
        if (stage_q == wve_pkg::STG_ON) begin
            playing_q = 1'b1;
            level_q   = 24'((v * 64'd524288 + 64'd5) / 64'd10);
            stage_q   = wve_pkg::STG_ATTACK;
        end
        e = 64'(level_q);
        case (stage_q)
            wve_pkg::STG_ATTACK: begin
                if (e > v * ATTACK_PEAK) stage_q = wve_pkg::STG_DECAY;
                else level_q = scale_level(level_q, ATTACK_GAIN);
            end
            wve_pkg::STG_DECAY: begin
                if (e * 10 < v * DECAY_FLOOR) stage_q = wve_pkg::STG_SUSTAIN;
                else level_q = scale_level(level_q, DECAY_GAIN);
            end
            wve_pkg::STG_RELEASE: begin
                if (e * 10 < v * RELEASE_FLOOR) stage_q = wve_pkg::STG_OFF;
                else level_q = scale_level(level_q, RELEASE_GAIN);
            end
            wve_pkg::STG_OFF: begin
                level_q   = SILENT_LEVEL;
                playing_q = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic voice_res_t predict_voice_result(voice_req_t r);
        voice_res_t res;
        longint     s;
        longint     p;
        res.sample = '0;
        case (r.op)
            wve_pkg::OP_TICK: begin
                if (playing_q) begin
                    phase_acc = phase_acc + 32'(phase_inc);
                    if (phase_acc >= PHASE_LIMIT) begin
                        advance_envelope();
                        phase_acc = phase_acc - PHASE_LIMIT;
                        if (phase_acc >= PHASE_LIMIT) phase_acc = phase_acc - PHASE_LIMIT;
                    end
                    // The sample is taken even on the wrap that silences the voice.
                    s = wave_mem[(phase_acc >> 16) % TABLE_LEN];
                    p = s * longint'(level_q);
                    p = (p + 32768) >>> 16;
                    if (p > 8388607) p = 8388607;
                    else if (p < -8388608) p = -8388608;
                    res.sample = p[23:0];
                end
            end
            wve_pkg::OP_NOTE_ON: begin
                playing_q = 1'b1;
                stage_q   = wve_pkg::STG_ON;
                vel_q     = r.vel;
                note_q    = r.note;
                phase_inc = note_pitch_step(r.note);
            end
            wve_pkg::OP_NOTE_OFF: stage_q = wve_pkg::STG_RELEASE;
            wve_pkg::OP_TABLE_WRITE: begin
                if (r.addr < TABLE_LEN) wave_mem[r.addr] = r.word;
            end
            default: ;
        endcase
        res.active = playing_q;
        res.note   = note_q;
        res.stage  = stage_q;
        return res;
    endfunction

    function automatic voice_req_t random_request(wve_pkg::t_op op);
        voice_req_t r;
        r.op   = op;
        r.note = 7'($urandom);
        r.vel  = 7'($urandom);
        r.addr = 11'($urandom);
        r.word = 16'($urandom);
        return r;
    endfunction

    function automatic void add_row(bit load, wve_pkg::t_op op, int note, int vel, int addr,
                                    int word, bit typed, bit active, int cur_note,
                                    wve_pkg::t_stage stg);
        directed_row_t row;
        row.load_table = load;
        row.req.op     = op;
        row.req.note   = 7'(note);
        row.req.vel    = 7'(vel);
        row.req.addr   = 11'(addr);
        row.req.word   = 16'(word);
        row.typed      = typed;
        row.res.sample = '0;
        row.res.active = active;
        row.res.note   = 7'(cur_note);
        row.res.stage  = stg;
        directed_rows.push_back(row);
    endfunction

    // Valid stays high from one request to the next when no gap is drawn.
    task automatic send_request(input voice_req_t r, input bit use_typed = 1'b0,
                                input voice_res_t typed_res = '0);
        int         gap;
        voice_res_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            ev_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ev_if.valid         <= 1'b1;
        ev_if.op            <= r.op;
        ev_if.note_number   <= r.note;
        ev_if.velocity      <= r.vel;
        ev_if.table_address <= r.addr;
        ev_if.table_word    <= r.word;
        do @(posedge clk); while (ev_if.ready !== 1'b1);
        predicted = predict_voice_result(r);
        pending_voice_results.push_back(use_typed ? typed_res : predicted);
        sent_count++;
    endtask

    task automatic hold_until_drained();
        ev_if.valid <= 1'b0;
        do @(posedge clk); while (pending_voice_results.size() != 0);
    endtask

    // A run of ticks with the odd stray request mixed in.
    task automatic play_ticks(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 24) == 0)
                send_request(random_request(wve_pkg::t_op'($urandom_range(0, 3))));
            else
                send_request(random_request(wve_pkg::OP_TICK));
        end
    endtask

    initial begin
        voice_req_t r;
        int         rand_base;
        bit         long_run;
        rst_n               <= 1'b0;
        ev_if.valid         <= 1'b0;
        ev_if.op            <= wve_pkg::OP_TICK;
        ev_if.note_number   <= '0;
        ev_if.velocity      <= '0;
        ev_if.table_address <= '0;
        ev_if.table_word    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Idle voice straight after reset; writes past the table end are dropped.
        add_row(0, wve_pkg::OP_TICK, 0, 0, 0, 0, 1, 0, 69, wve_pkg::STG_ATTACK);
        add_row(0, wve_pkg::OP_TABLE_WRITE, 127, 127, 1600, 32767, 1, 0, 69,
                wve_pkg::STG_ATTACK);
        add_row(0, wve_pkg::OP_TABLE_WRITE, 0, 0, 2047, -32768, 1, 0, 69,
                wve_pkg::STG_ATTACK);
        add_row(0, wve_pkg::OP_NOTE_OFF, 127, 127, 2047, -1, 1, 0, 69, wve_pkg::STG_RELEASE);
        add_row(0, wve_pkg::OP_TICK, 127, 127, 2047, 32767, 1, 0, 69, wve_pkg::STG_RELEASE);
        // From here the whole table holds data.
        add_row(1, wve_pkg::OP_NOTE_ON, 127, 127, 0, 0, 1, 1, 127, wve_pkg::STG_ON);
        add_row(0, wve_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, wve_pkg::STG_ON);
        add_row(0, wve_pkg::OP_TICK, 127, 127, 2047, -1, 0, 0, 0, wve_pkg::STG_ON);
        add_row(0, wve_pkg::OP_NOTE_ON, 0, 0, 0, 0, 1, 1, 0, wve_pkg::STG_ON);
        // Zero velocity: the first wrap leaves the level at zero in attack.
        add_row(0, wve_pkg::OP_NOTE_ON, 127, 0, 0, 0, 1, 1, 127, wve_pkg::STG_ON);
        for (int i = 0; i < 4; i++)
            add_row(0, wve_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, wve_pkg::STG_ON);
        // Release from a zero level ends at once; the next wrap silences the voice.
        add_row(0, wve_pkg::OP_NOTE_ON, 127, 127, 0, 0, 1, 1, 127, wve_pkg::STG_ON);
        add_row(0, wve_pkg::OP_NOTE_OFF, 0, 0, 0, 0, 1, 1, 127, wve_pkg::STG_RELEASE);
        for (int i = 0; i < 8; i++)
            add_row(0, wve_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, wve_pkg::STG_ON);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].load_table) begin
                for (int a = 0; a < TABLE_LEN; a++) begin
                    if (a % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
                    r      = random_request(wve_pkg::OP_TABLE_WRITE);
                    r.addr = 11'(a);
                    if (a == 0) r.word = 16'sh7FFF;
                    else if (a == 1) r.word = 16'sh8000;
                    send_request(r);
                end
                hold_until_drained();
            end
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
        end

        // The first sequence holds a top note long enough to reach sustain.
        rand_base = sent_count;
        long_run  = 1'b1;
        while (sent_count - rand_base < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) hold_until_drained();
            if (!long_run && $urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 8))
                    send_request(random_request(wve_pkg::t_op'($urandom_range(0, 3))));
            end else begin
                r = random_request(wve_pkg::OP_NOTE_ON);
                if (long_run) r.note = 7'd127;
                else if ($urandom_range(0, 6) != 0) r.note = 7'($urandom_range(100, 127));
                if ($urandom_range(0, 9) == 0) r.vel = '0;
                send_request(r);
                play_ticks(long_run ? 420 : $urandom_range(4, 60));
                if (long_run || $urandom_range(0, 1) == 1) begin
                    send_request(random_request(wve_pkg::OP_NOTE_OFF));
                    play_ticks(long_run ? 60 : $urandom_range(10, 40));
                end
                long_run = 1'b0;
            end
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_voice_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: a random stall before each result, counted while one is offered.
    initial begin
        int         stall_left;
        voice_res_t want;
        voice_res_t got;
        res_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 15);
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                got.sample = res_if.sample_out;
                got.active = res_if.voice_active;
                got.note   = res_if.current_note;
                got.stage  = res_if.envelope_stage;
                if (pending_voice_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("result %0d with no request behind it: sample %0d active %0b",
                                 results_seen, got.sample, got.active);
                    mismatch_count++;
                end else begin
                    want = pending_voice_results.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < 10)
                            $display({"result %0d: expected sample %0d active %0b note %0d ",
                                      "stage %0d, got sample %0d active %0b note %0d stage %0d"},
                                     results_seen, want.sample, want.active, want.note,
                                     want.stage, got.sample, got.active, got.note, got.stage);
                        mismatch_count++;
                    end
                end
                results_seen++;
                stall_left = no_idle ? 0 : $urandom_range(0, 15);
            end else if (stall_left > 0 && res_if.valid === 1'b1) begin
                stall_left--;
            end
            res_if.ready <= (rst_n === 1'b1) && (stall_left == 0);
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((ev_if.valid === 1'b1 && ev_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
